FILE: rtl/delr_pkg.sv
// Shared types and fixed constants of the dual-energy log ratio block.
package delr_pkg;

   localparam int unsigned FIELD_W    = 18;
   localparam int unsigned OUT_W      = 24;
   localparam int unsigned SQRT_STEPS = 25;

   localparam logic [OUT_W-1:0] OUT_MAX = '1;
   // ln(2) in Q0.32
   localparam logic [31:0]      LN2_Q32 = 32'd2977044472;

   typedef enum logic [1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_SCAN    = 2'd1,
      REQ_COMPUTE = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_DIVZERO = 2'd1,
      STATUS_SAT    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MUL_DL = 2'd0,
      MUL_DH = 2'd1,
      MUL_AE = 2'd2
   } mul_job_type;

   typedef enum logic [1:0] {
      DIV_RATIO  = 2'd0,
      DIV_TERM1  = 2'd1,
      DIV_TERM2A = 2'd2,
      DIV_TERM2B = 2'd3
   } div_job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG_INIT,
      ST_LOG_SQ,
      ST_LOG_MAG,
      ST_LOG_LN1,
      ST_LOG_LN2,
      ST_PREP,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_DIV_DONE,
      ST_SQ_T1,
      ST_SQ_T2,
      ST_SQRT,
      ST_FINISH
   } state_type;

endpackage

FILE: rtl/dual_energy_log_ratio.sv
// Dual-energy log transmission ratio with propagated uncertainty, bit-serial datapath.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   req     | in        | req_valid/req_stall  | req_type, trans_low/high, err_low/high
//   rsp     | out       | rsp_valid/rsp_stall  | ratio_value, ratio_error, status
//
// A clear or scan beat is absorbed in the cycle it is accepted and gives no response.
// A compute beat runs the whole sequence: the two logarithms cost 32 squaring steps
// each on the shared 32x32 multiplier, and the four quotients go through the
// restoring divider one quotient bit per cycle; the square root adds 25 two-bit steps.
// A zero low log or an early saturation shortens the sequence.
// Reset is synchronous and restores both minima to 1.0; the request side is stalled
// whenever the sequencer is busy, while a finished beat waits in the response register.
module dual_energy_log_ratio
   import delr_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [FIELD_W-1:0] req_trans_low,
   input  logic [FIELD_W-1:0] req_trans_high,
   input  logic [FIELD_W-1:0] req_err_low,
   input  logic [FIELD_W-1:0] req_err_high,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [OUT_W-1:0]   rsp_ratio_value,
   output logic [OUT_W-1:0]   rsp_ratio_error,
   output logic [1:0]         rsp_status
);

   // Transmissions after substitution never exceed 1.0, so FRAC_BITS+1 bits hold them.
   localparam int unsigned TW   = FRAC_BITS + 1;
   localparam int unsigned HW   = $clog2(FRAC_BITS + 1);
   localparam int unsigned LW   = 32 + HW;              // ln magnitude, Q.32
   localparam int unsigned DW   = TW + LW;              // T * L
   localparam int unsigned AW   = LW + FIELD_W;         // Lh * el
   localparam int unsigned PRW  = LW + 32;              // two-part product
   localparam int unsigned NW   = AW + 32 + FRAC_BITS;  // widest dividend
   localparam int unsigned KMAX = OUT_W + LW;           // longest quotient
   localparam int unsigned CW   = $clog2(KMAX);
   localparam int unsigned XW   = 2 * OUT_W + 1;        // sum of squares
   localparam int unsigned CMPW = (FIELD_W > TW) ? FIELD_W : TW;
   localparam logic [TW-1:0] ONE    = TW'(1) << FRAC_BITS;
   localparam logic [HW-1:0] FRAC_H = HW'(FRAC_BITS);

   state_type   state_ff, state_in;
   logic [TW-1:0] min_low_ff, min_high_ff;
   logic [TW-1:0] tl_ff, th_ff;
   logic [FIELD_W-1:0] el_ff, eh_ff;
   logic          lg_sel_ff;
   logic [31:0]   m_ff, frac_ff;
   logic [HW-1:0] p_ff;
   logic [CW-1:0] cnt_ff;
   logic [LW-1:0] mag_ff, ll_ff, lh_ff;
   logic [63:0]   acc_ff;
   mul_job_type   mjob_ff;
   div_job_type   djob_ff;
   logic [DW-1:0] dl_ff, dh_ff;
   logic [AW-1:0] ae_ff;
   logic [DW-1:0] rem_ff, dd_ff;
   logic [KMAX-1:0] lo_ff, quo_ff;
   logic [OUT_W-1:0] ratio_ff, t1_ff, t2_ff, err_ff;
   logic          sat_ff, esat_ff, divz_ff;
   logic [XW-1:0] x_ff, r_ff, bit_ff;
   logic          rsp_valid_ff;
   logic [OUT_W-1:0] rsp_value_ff, rsp_error_ff;
   status_type    rsp_status_ff;

   logic          req_fire, out_load;
   logic [TW-1:0] sub_low, sub_high;
   logic          scan_low, scan_high;
   logic [TW-1:0] lg_raw;
   logic [HW-1:0] lg_p;
   logic [31:0]   lg_m;
   logic [32:0]   sq_s;
   logic [LW-1:0] mag_new, ln_new;
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_p;
   logic [LW-1:0] mop_src;
   logic [31:0]   mop_b;
   logic [PRW-1:0] mop_res;
   logic [NW-1:0] div_n, div_top;
   logic [DW-1:0] div_d;
   logic          div_wide, div_over;
   logic [KMAX-1:0] div_lo;
   logic [DW:0]   div_t, div_r;
   logic          div_ge;
   logic [XW-1:0] sr_sum;
   logic          sr_ge;

   assign req_fire        = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ratio_value = rsp_value_ff;
   assign rsp_ratio_error = rsp_error_ff;
   assign rsp_status      = rsp_status_ff;

   // Substitute a zero transmission with its minimum, clamp anything above 1.0.
   always_comb begin
      if (req_trans_low == '0) begin
         sub_low = min_low_ff;
      end else if (CMPW'(req_trans_low) > CMPW'(ONE)) begin
         sub_low = ONE;
      end else begin
         sub_low = TW'(req_trans_low);
      end
      if (req_trans_high == '0) begin
         sub_high = min_high_ff;
      end else if (CMPW'(req_trans_high) > CMPW'(ONE)) begin
         sub_high = ONE;
      end else begin
         sub_high = TW'(req_trans_high);
      end
      scan_low  = (req_trans_low != '0) && (CMPW'(req_trans_low) < CMPW'(min_low_ff));
      scan_high = (req_trans_high != '0) && (CMPW'(req_trans_high) < CMPW'(min_high_ff));
   end

   // Normalise the operand of the current logarithm to a Q1.31 mantissa.
   always_comb begin
      lg_raw = lg_sel_ff ? th_ff : tl_ff;
      if (lg_raw == '0) begin
         lg_raw = TW'(1);
      end
      lg_p = '0;
      for (int i = 0; i < TW; i++) begin
         if (lg_raw[i]) begin
            lg_p = HW'(i);
         end
      end
      lg_m = 32'(lg_raw) << (5'd31 - 5'(lg_p));
   end

   // Square result back in Q1.31 (one guard bit on top), magnitude and ln scaling.
   assign sq_s    = mul_p[63:31];
   assign mag_new = {FRAC_H - p_ff, 32'd0} - {{HW{1'b0}}, frac_ff};
   assign ln_new  = LW'(acc_ff[63:32]) + LW'(mul_p);

   // Operands of the two-part products T*L and Lh*el.
   always_comb begin
      mop_src = (mjob_ff == MUL_AE) ? lh_ff : ll_ff;
      case (mjob_ff)
         MUL_DL:  mop_b = 32'(tl_ff);
         MUL_DH:  mop_b = 32'(th_ff);
         default: mop_b = 32'(el_ff);
      endcase
      mop_res = PRW'(acc_ff) + (PRW'(mul_p) << 32);
   end

   // Dividend and divisor of each quotient; the wide one runs KMAX steps.
   always_comb begin
      div_n    = '0;
      div_d    = '0;
      div_wide = 1'b0;
      unique case (djob_ff)
         DIV_RATIO: begin
            div_n = NW'(lh_ff) << FRAC_BITS;
            div_d = DW'(ll_ff);
         end
         DIV_TERM1: begin
            div_n = NW'(eh_ff) << (32 + FRAC_BITS);
            div_d = dh_ff;
         end
         DIV_TERM2A: begin
            div_n    = NW'(ae_ff) << (32 + FRAC_BITS);
            div_d    = dl_ff;
            div_wide = 1'b1;
         end
         DIV_TERM2B: begin
            div_n = NW'(quo_ff);
            div_d = DW'(ll_ff);
         end
         default: ;
      endcase
      div_top  = div_wide ? (div_n >> KMAX) : (div_n >> OUT_W);
      // A quotient that would not fit the step count is already saturated.
      div_over = div_top >= NW'(div_d);
      div_lo   = div_wide ? div_n[KMAX-1:0]
                          : {div_n[OUT_W-1:0], {(KMAX - OUT_W){1'b0}}};
      div_t    = {rem_ff, lo_ff[KMAX-1]};
      div_r    = div_t - {1'b0, dd_ff};
      div_ge   = div_t >= {1'b0, dd_ff};
      sr_sum   = r_ff + bit_ff;
      sr_ge    = x_ff >= sr_sum;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_type == REQ_COMPUTE) begin
               state_in = ST_LOG_INIT;
            end
         end
         ST_LOG_INIT: state_in = ST_LOG_SQ;
         ST_LOG_SQ: begin
            if (cnt_ff == '0) begin
               state_in = ST_LOG_MAG;
            end
         end
         ST_LOG_MAG: state_in = ST_LOG_LN1;
         ST_LOG_LN1: state_in = ST_LOG_LN2;
         ST_LOG_LN2: state_in = lg_sel_ff ? ST_PREP : ST_LOG_INIT;
         ST_PREP:    state_in = (ll_ff == '0) ? ST_FINISH : ST_MUL_LO;
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = (mjob_ff == MUL_AE) ? ST_DIV_INIT : ST_MUL_LO;
         ST_DIV_INIT: begin
            if (!div_over) begin
               state_in = ST_DIV_STEP;
            end else if (djob_ff == DIV_TERM2A || djob_ff == DIV_TERM2B) begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV_STEP: begin
            if (cnt_ff == '0) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE: begin
            if (djob_ff != DIV_TERM2B) begin
               state_in = ST_DIV_INIT;
            end else begin
               state_in = esat_ff ? ST_FINISH : ST_SQ_T1;
            end
         end
         ST_SQ_T1: state_in = ST_SQ_T2;
         ST_SQ_T2: state_in = ST_SQRT;
         ST_SQRT: begin
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake and multiplier operand selection.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      out_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         ST_LOG_SQ: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         ST_LOG_LN1: begin
            mul_a = mag_ff[31:0];
            mul_b = LN2_Q32;
         end
         ST_LOG_LN2: begin
            mul_a = 32'(mag_ff[LW-1:32]);
            mul_b = LN2_Q32;
         end
         ST_MUL_LO: begin
            mul_a = mop_src[31:0];
            mul_b = mop_b;
         end
         ST_MUL_HI: begin
            mul_a = 32'(mop_src[LW-1:32]);
            mul_b = mop_b;
         end
         ST_SQ_T1: begin
            mul_a = 32'(t1_ff);
            mul_b = 32'(t1_ff);
         end
         ST_SQ_T2: begin
            mul_a = 32'(t2_ff);
            mul_b = 32'(t2_ff);
         end
         default: ;
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   // Control registers and running minima.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         min_low_ff   <= ONE;
         min_high_ff  <= ONE;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end
         if (req_fire) begin
            unique case (req_type)
               REQ_CLEAR: begin
                  min_low_ff  <= ONE;
                  min_high_ff <= ONE;
               end
               REQ_SCAN: begin
                  if (scan_low) begin
                     min_low_ff <= TW'(req_trans_low);
                  end
                  if (scan_high) begin
                     min_high_ff <= TW'(req_trans_high);
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Datapath: latch the beat, iterate the logs, products, quotients and root.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            tl_ff     <= sub_low;
            th_ff     <= sub_high;
            el_ff     <= req_err_low;
            eh_ff     <= req_err_high;
            lg_sel_ff <= 1'b0;
         end
         ST_LOG_INIT: begin
            m_ff    <= lg_m;
            p_ff    <= lg_p;
            frac_ff <= '0;
            cnt_ff  <= CW'(31);
         end
         ST_LOG_SQ: begin
            // A square of 2.0 or more yields a one bit and halves the mantissa.
            if (sq_s[32]) begin
               m_ff    <= sq_s[32:1];
               frac_ff <= {frac_ff[30:0], 1'b1};
            end else begin
               m_ff    <= sq_s[31:0];
               frac_ff <= {frac_ff[30:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
         end
         ST_LOG_MAG: mag_ff <= mag_new;
         ST_LOG_LN1: acc_ff <= mul_p;
         ST_LOG_LN2: begin
            if (lg_sel_ff) begin
               lh_ff <= ln_new;
            end else begin
               ll_ff <= ln_new;
            end
            lg_sel_ff <= 1'b1;
         end
         ST_PREP: begin
            sat_ff   <= 1'b0;
            esat_ff  <= 1'b0;
            divz_ff  <= (ll_ff == '0);
            ratio_ff <= '0;
            err_ff   <= '0;
            mjob_ff  <= MUL_DL;
            djob_ff  <= DIV_RATIO;
         end
         ST_MUL_LO: acc_ff <= mul_p;
         ST_MUL_HI: begin
            unique case (mjob_ff)
               MUL_DL: begin
                  dl_ff   <= DW'(mop_res);
                  mjob_ff <= MUL_DH;
               end
               MUL_DH: begin
                  dh_ff   <= DW'(mop_res);
                  mjob_ff <= MUL_AE;
               end
               default: ae_ff <= AW'(mop_res);
            endcase
         end
         ST_DIV_INIT: begin
            if (div_over) begin
               sat_ff <= 1'b1;
               if (djob_ff == DIV_RATIO) begin
                  ratio_ff <= OUT_MAX;
                  djob_ff  <= DIV_TERM1;
               end else begin
                  err_ff  <= OUT_MAX;
                  esat_ff <= 1'b1;
                  djob_ff <= DIV_TERM2A;
               end
            end else begin
               rem_ff <= DW'(div_top);
               lo_ff  <= div_lo;
               quo_ff <= '0;
               dd_ff  <= div_d;
               cnt_ff <= div_wide ? CW'(KMAX - 1) : CW'(OUT_W - 1);
            end
         end
         ST_DIV_STEP: begin
            rem_ff <= div_ge ? div_r[DW-1:0] : div_t[DW-1:0];
            lo_ff  <= lo_ff << 1;
            quo_ff <= {quo_ff[KMAX-2:0], div_ge};
            cnt_ff <= cnt_ff - 1'b1;
         end
         ST_DIV_DONE: begin
            unique case (djob_ff)
               DIV_RATIO: begin
                  ratio_ff <= quo_ff[OUT_W-1:0];
                  djob_ff  <= DIV_TERM1;
               end
               DIV_TERM1: begin
                  t1_ff   <= quo_ff[OUT_W-1:0];
                  djob_ff <= DIV_TERM2A;
               end
               DIV_TERM2A: djob_ff <= DIV_TERM2B;
               default:    t2_ff   <= quo_ff[OUT_W-1:0];
            endcase
         end
         ST_SQ_T1: x_ff <= XW'(mul_p);
         ST_SQ_T2: begin
            x_ff   <= x_ff + XW'(mul_p);
            r_ff   <= '0;
            bit_ff <= XW'(1) << (XW - 1);
            cnt_ff <= CW'(SQRT_STEPS - 1);
         end
         ST_SQRT: begin
            if (sr_ge) begin
               x_ff <= x_ff - sr_sum;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (sr_ge && (((r_ff >> 1) + bit_ff) > XW'(OUT_MAX))) begin
                  err_ff <= OUT_MAX;
                  sat_ff <= 1'b1;
               end else if (!sr_ge && ((r_ff >> 1) > XW'(OUT_MAX))) begin
                  err_ff <= OUT_MAX;
                  sat_ff <= 1'b1;
               end else if (sr_ge) begin
                  err_ff <= OUT_W'((r_ff >> 1) + bit_ff);
               end else begin
                  err_ff <= OUT_W'(r_ff >> 1);
               end
            end
         end
         ST_FINISH: begin
            if (out_load) begin
               rsp_value_ff <= ratio_ff;
               rsp_error_ff <= err_ff;
               if (divz_ff) begin
                  rsp_status_ff <= STATUS_DIVZERO;
               end else if (sat_ff) begin
                  rsp_status_ff <= STATUS_SAT;
               end else begin
                  rsp_status_ff <= STATUS_OK;
               end
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_min_range: assert property (@(posedge clock) disable iff (reset)
      (min_low_ff != '0) && (min_low_ff <= ONE) && (min_high_ff != '0) && (min_high_ff <= ONE))
      else $error("running minimum left the range 1 LSB to 1.0");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_STEP) |-> (rem_ff < dd_ff))
      else $error("divider remainder not below divisor");

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_DIVZERO) |->
      (rsp_ratio_value == '0 && rsp_ratio_error == '0))
      else $error("zero low log beat carries non-zero fields");

   a_compute_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type == REQ_COMPUTE) |=> (state_ff == ST_LOG_INIT))
      else $error("compute beat did not start the log sequence");
`endif

endmodule

FILE: tb/dual_energy_log_ratio_checker.sv
// Checker for the dual-energy log ratio block: predicts each response beat and compares it.
module dual_energy_log_ratio_checker
   import delr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [FIELD_W-1:0] req_trans_low,
   input  logic [FIELD_W-1:0] req_trans_high,
   input  logic [FIELD_W-1:0] req_err_low,
   input  logic [FIELD_W-1:0] req_err_high,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [OUT_W-1:0]   rsp_ratio_value,
   input  logic [OUT_W-1:0]   rsp_ratio_error,
   input  logic [1:0]         rsp_status,
   output int                 fail_count,
   output int                 pending,
   output int                 checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRAC = 16;
   localparam logic [FIELD_W-1:0] ONE = 18'd1 << FRAC;

   typedef struct packed {
      logic [OUT_W-1:0] ratio_value;
      logic [OUT_W-1:0] ratio_error;
      status_type       status;
   } ratio_beat_type;

   ratio_beat_type ratio_queue[$];
   logic [FIELD_W-1:0] min_low, min_high;

   // floor(a*b/c); zero when c is zero or the quotient overflows 64 bits
   function automatic bit scaled_quotient(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] c, output logic [63:0] q);
      logic [127:0] prod, quo;
      q = '0;
      if (c == 0) return 1'b0;
      prod = 128'(a) * 128'(b);
      quo = prod / 128'(c);
      if (quo[127:64] != 0) return 1'b0;
      q = quo[63:0];
      return 1'b1;
   endfunction

   // -ln(raw / 2^FRAC) in Q.32 via repeated squaring of the mantissa
   function automatic logic [63:0] neg_log_q32(input logic [FIELD_W-1:0] raw);
      logic [63:0] m, mag;
      logic [31:0] frac;
      logic [127:0] prod;
      int p;
      p = 0;
      frac = '0;
      for (int b = 0; b < FIELD_W; b++) if (raw[b]) p = b;
      if (p > FRAC) p = FRAC;
      m = 64'(raw) << (31 - p);
      for (int i = 0; i < 32; i++) begin
         m = (m * m) >> 31;
         frac = {frac[30:0], 1'b0};
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      mag = (64'(FRAC - p) << 32) - 64'(frac);
      prod = 128'(mag) * 128'(LN2_Q32);
      return prod[95:32];
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] x);
      logic [63:0] r, trial;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= x) r = trial;
      end
      return r;
   endfunction

   function automatic ratio_beat_type predict_ratio(input logic [FIELD_W-1:0] tl_in,
                                                    input logic [FIELD_W-1:0] th_in,
                                                    input logic [FIELD_W-1:0] el,
                                                    input logic [FIELD_W-1:0] eh,
                                                    input logic [FIELD_W-1:0] lo_min,
                                                    input logic [FIELD_W-1:0] hi_min);
      logic [FIELD_W-1:0] tl, th;
      logic [63:0] ll, lh, ratio, t1, t2, q, err, scale, big;
      ratio_beat_type res;
      bit sat;
      tl = (tl_in == 0) ? lo_min : (tl_in > ONE) ? ONE : tl_in;
      th = (th_in == 0) ? hi_min : (th_in > ONE) ? ONE : th_in;
      ll = neg_log_q32(tl);
      lh = neg_log_q32(th);
      if (ll == 0) begin
         res.ratio_value = '0;
         res.ratio_error = '0;
         res.status = STATUS_DIVZERO;
         return res;
      end
      sat = 1'b0;
      big = 64'(OUT_MAX) + 1;
      scale = 64'd1 << (32 + FRAC);
      if (!scaled_quotient(lh, 64'(ONE), ll, ratio) || ratio > 64'(OUT_MAX)) begin
         ratio = 64'(OUT_MAX);
         sat = 1'b1;
      end
      if (!scaled_quotient(64'(eh), scale, 64'(th) * ll, t1) || t1 > 64'(OUT_MAX)) t1 = big;
      if (!scaled_quotient(lh * 64'(el), scale, 64'(tl) * ll, q)) begin
         t2 = big;
      end else begin
         t2 = q / ll;
         if (t2 > 64'(OUT_MAX)) t2 = big;
      end
      if (t1 == big || t2 == big) begin
         err = 64'(OUT_MAX);
         sat = 1'b1;
      end else begin
         err = floor_root(t1 * t1 + t2 * t2);
         if (err > 64'(OUT_MAX)) begin
            err = 64'(OUT_MAX);
            sat = 1'b1;
         end
      end
      res.ratio_value = err[OUT_W-1:0] == 0 ? ratio[OUT_W-1:0] : ratio[OUT_W-1:0];
      res.ratio_error = err[OUT_W-1:0];
      res.status = sat ? STATUS_SAT : STATUS_OK;
      return res;
   endfunction

   assign pending = ratio_queue.size();

   always @(posedge clock) begin
      ratio_beat_type want;
      if (reset) begin
         min_low <= ONE;
         min_high <= ONE;
         ratio_queue.delete();
         fail_count <= 0;
         checked_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            case (req_type)
               REQ_CLEAR: begin
                  min_low <= ONE;
                  min_high <= ONE;
               end
               REQ_SCAN: begin
                  if (req_trans_low != 0 && req_trans_low < min_low) min_low <= req_trans_low;
                  if (req_trans_high != 0 && req_trans_high < min_high)
                     min_high <= req_trans_high;
               end
               REQ_COMPUTE: ratio_queue.push_back(predict_ratio(req_trans_low, req_trans_high,
                                                  req_err_low, req_err_high, min_low, min_high));
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            checked_count <= checked_count + 1;
            if (ratio_queue.size() == 0) begin
               $display("%0t: response beat with nothing expected (%h %h %0d)", $time,
                        rsp_ratio_value, rsp_ratio_error, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               want = ratio_queue.pop_front();
               if (rsp_ratio_value !== want.ratio_value || rsp_ratio_error !== want.ratio_error
                   || rsp_status !== want.status) begin
                  $display("%0t: mismatch expected value %h error %h status %0d", $time,
                           want.ratio_value, want.ratio_error, want.status);
                  $display("%0t:          actual   value %h error %h status %0d", $time,
                           rsp_ratio_value, rsp_ratio_error, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: tb/dual_energy_log_ratio_tb.sv
// Top of the dual-energy log ratio testbench: clock, reset, stimulus and verdict.
module dual_energy_log_ratio_tb;
   import delr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [FIELD_W-1:0] ONE = 18'd65536;
   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int DRAIN_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = REQ_CLEAR;
   logic [FIELD_W-1:0] req_trans_low = '0, req_trans_high = '0;
   logic [FIELD_W-1:0] req_err_low = '0, req_err_high = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [OUT_W-1:0] rsp_ratio_value, rsp_ratio_error;
   logic [1:0] rsp_status;

   int fail_count, pending, checked_count;
   int cycle_count = 0;
   int beats_sent = 0;
   int burst_left = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   dual_energy_log_ratio u_dut (.*);

   dual_energy_log_ratio_checker u_checker (.*);

   always #1 clock = ~clock;

   // Cycle counter doubles as the watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: stretches of free flow, light and heavy stalling, plus two long
   // hold-offs that back the block up so that it stalls its request side
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (cycle_count == 30000 || cycle_count == 150000) begin
         rsp_stall <= 1'b1;
         hold_left <= 2500;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(50, 800);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Offer one beat and hold it until taken; drop valid between bursts
   task automatic send_beat(input logic [1:0] kind, input logic [FIELD_W-1:0] tl,
                            input logic [FIELD_W-1:0] th, input logic [FIELD_W-1:0] el,
                            input logic [FIELD_W-1:0] eh);
      int gap;
      req_valid <= 1'b1;
      req_type <= kind;
      req_trans_low <= tl;
      req_trans_high <= th;
      req_err_low <= el;
      req_err_high <= eh;
      do @(posedge clock); while (req_stall);
      if (kind != REQ_UNUSED) beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
         burst_left = $urandom_range(1, 30);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Any field value over the whole 18-bit range
   function automatic logic [FIELD_W-1:0] any_field();
      return FIELD_W'($urandom_range(0, 262143));
   endfunction

   // Transmission with weight on the interesting regions: zero, above 1.0, exactly 1.0, tiny, just below 1.0
   function automatic logic [FIELD_W-1:0] pick_trans();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return FIELD_W'($urandom_range(65537, 262143));
         2: return ONE;
         3: return FIELD_W'($urandom_range(1, 255));
         4: return FIELD_W'($urandom_range(65000, 65535));
         default: return FIELD_W'($urandom_range(1, 65535));
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] pick_err();
      case ($urandom_range(0, 7))
         0: return any_field();
         1: return '0;
         default: return FIELD_W'($urandom_range(0, 4095));
      endcase
   endfunction

   initial begin
      int scans, computes;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every request code, and the special cases
      send_beat(REQ_COMPUTE, 18'd0, 18'd0, 18'd100, 18'd100);          // minima still 1.0
      send_beat(REQ_COMPUTE, ONE, 18'd32768, 18'd10, 18'd10);          // low log zero
      send_beat(REQ_COMPUTE, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF); // clamp to 1.0
      send_beat(REQ_SCAN, 18'd1, 18'd1, 18'h3FFFF, 18'h3FFFF);
      send_beat(REQ_SCAN, 18'd0, 18'd0, 18'd0, 18'd0);                   // zero not a minimum
      send_beat(REQ_COMPUTE, 18'd0, 18'd0, 18'd1, 18'd1);              // both from minima
      send_beat(REQ_COMPUTE, 18'd1, 18'd1, 18'h3FFFF, 18'h3FFFF);       // deepest logs
      send_beat(REQ_COMPUTE, 18'd65535, 18'd1, 18'd0, 18'd0);           // ratio saturates
      send_beat(REQ_COMPUTE, 18'd65535, 18'd65535, 18'h3FFFF, 18'h3FFFF); // error saturates
      send_beat(REQ_COMPUTE, 18'd1, ONE, 18'd50, 18'd50);               // zero ratio
      send_beat(REQ_UNUSED, 18'd1, 18'd1, 18'd1, 18'd1);                // ignored code
      send_beat(REQ_CLEAR, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
      send_beat(REQ_COMPUTE, 18'd0, 18'd0, 18'd7, 18'd7);
      send_beat(REQ_SCAN, 18'd40000, 18'h2AAAA, 18'd0, 18'd0);
      send_beat(REQ_SCAN, 18'd20000, 18'd12345, 18'd0, 18'd0);
      send_beat(REQ_COMPUTE, 18'd0, 18'd0, 18'h15555, 18'h2AAAA);
      send_beat(REQ_COMPUTE, 18'd32768, 18'd16384, 18'd655, 18'd655);

      // Random: mostly clear/scan/compute passes with random content, some noise
      while (beats_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 85) begin
            send_beat(REQ_CLEAR, any_field(), any_field(), any_field(), any_field());
            scans = $urandom_range(1, 6);
            computes = $urandom_range(1, 8);
            repeat (scans) send_beat(REQ_SCAN, pick_trans(), pick_trans(), pick_err(),
                                     pick_err());
            repeat (computes) send_beat(REQ_COMPUTE, pick_trans(), pick_trans(), pick_err(),
                                        pick_err());
         end else begin
            send_beat(2'($urandom_range(0, 3)), any_field(), any_field(), any_field(),
                      any_field());
         end
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then allow for anything unexpected
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats (clear, scan, compute); checked %0d responses,",
               beats_sent, checked_count);
      $display("covering minima substitution, clamping, low log zero and saturation.");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/delr_pkg.sv
rtl/dual_energy_log_ratio.sv
tb/dual_energy_log_ratio_checker.sv
tb/dual_energy_log_ratio_tb.sv
